// ----- sv/unordered_key_table_unit_assert.svh -----
// assertion macros for the unordered key table unit
// expects aclk and aresetn in the scope of use
`ifndef UNORDERED_KEY_TABLE_UNIT_ASSERT_SVH
`define UNORDERED_KEY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define UKT_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("key table check failed");

// next-cycle implication
`define UKT_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("key table check failed");

`endif

// ----- sv/ukt_pkg.sv -----
// shared types and constants of the unordered key table unit
// no dependencies
package ukt_pkg;

    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_LAST = 5'b00100,
        ST_MOVE = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

endpackage

// ----- sv/ukt_key_ram.sv -----
// key storage: single write port, single registered read port
// depends on ukt_pkg for the key width
module ukt_key_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [ukt_pkg::KEY_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [ukt_pkg::KEY_W-1:0]  rd_data
);

    logic [ukt_pkg::KEY_W-1:0] mem [DEPTH];
    logic [ukt_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/unordered_key_table_unit.sv -----
// unordered key table with swap remove; insert fills the next free slot, no scan
// lookup and remove scan the stored keys; an empty table skips the scan; remove hit
// adds ST_LAST (read of the last entry) and ST_MOVE (writeback into the hit slot);
// the unit returns to idle after each result, so one word is in flight at a time,
// and the scan reads one key per cycle over the ram read port
// synchronous active-low reset empties the table; key storage is not cleared
module unordered_key_table_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ukt_pkg::OP_W-1:0]           s_operation,
    input  logic signed [ukt_pkg::KEY_W-1:0]   s_key,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_success,
    output logic [ukt_pkg::SLOT_W-1:0]         m_slot,
    output logic [ukt_pkg::COUNT_W-1:0]        m_entry_count
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SPAD_W = (IDX_W > ukt_pkg::SLOT_W) ? IDX_W : ukt_pkg::SLOT_W;
    localparam int CPAD_W = (CNT_W > ukt_pkg::COUNT_W) ? CNT_W : ukt_pkg::COUNT_W;

    ukt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]               count_reg, count_next;
    logic [ukt_pkg::OP_W-1:0]       op_reg, op_next;
    logic [ukt_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [CNT_W-1:0]               issue_idx_reg, issue_idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic                           res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]               res_slot_reg, res_slot_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_success_reg, m_success_next;
    logic [ukt_pkg::SLOT_W-1:0]     m_slot_reg, m_slot_next;
    logic [ukt_pkg::COUNT_W-1:0]    m_count_reg, m_count_next;

    logic                           ram_wr_en;
    logic [IDX_W-1:0]               ram_wr_addr;
    logic [ukt_pkg::KEY_W-1:0]      ram_wr_data;
    logic                           ram_rd_en;
    logic [IDX_W-1:0]               ram_rd_addr;
    logic [ukt_pkg::KEY_W-1:0]      ram_rd_data;

    logic                           s_accept;
    logic                           issue_active;
    logic [CNT_W-1:0]               count_dec;
    logic [SPAD_W-1:0]              slot_wide;
    logic [CPAD_W-1:0]              count_wide;

    ukt_key_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready      = (state_reg == ukt_pkg::ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign issue_active = (issue_idx_reg < count_reg);
    assign count_dec    = count_reg - CNT_W'(1);
    assign slot_wide    = SPAD_W'(res_slot_reg);
    assign count_wide   = CPAD_W'(count_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        m_valid_next   = m_valid_reg;
        m_success_next = m_success_reg;
        m_slot_next    = m_slot_reg;
        m_count_next   = m_count_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = res_slot_reg;
        ram_wr_data    = key_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = issue_idx_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ukt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_operation;
                    key_next       = s_key;
                    issue_idx_next = '0;
                    cmp_valid_next = 1'b0;
                    res_ok_next    = 1'b0;
                    res_slot_next  = '0;
                    state_next     = ukt_pkg::ST_RESP;
                    unique case (s_operation) inside
                        ukt_pkg::OP_INSERT: begin
                            if (count_reg < CNT_W'(CAPACITY)) begin
                                ram_wr_en     = 1'b1;
                                ram_wr_addr   = count_reg[IDX_W-1:0];
                                ram_wr_data   = s_key;
                                count_next    = count_reg + CNT_W'(1);
                                res_ok_next   = 1'b1;
                                res_slot_next = count_reg[IDX_W-1:0];
                            end
                        end
                        ukt_pkg::OP_REMOVE, ukt_pkg::OP_LOOKUP: begin
                            if (count_reg != '0) begin
                                state_next = ukt_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ukt_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            ukt_pkg::ST_SCAN: begin
                // one read issued per cycle, compared the cycle after
                ram_rd_en      = issue_active;
                cmp_valid_next = issue_active;
                cmp_idx_next   = issue_idx_reg[IDX_W-1:0];
                if (issue_active) begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (cmp_valid_reg && (ram_rd_data == key_reg)) begin
                    res_ok_next    = 1'b1;
                    res_slot_next  = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = (op_reg == ukt_pkg::OP_REMOVE) ? ukt_pkg::ST_LAST
                                                                    : ukt_pkg::ST_RESP;
                end else if (cmp_valid_reg && !issue_active) begin
                    cmp_valid_next = 1'b0;
                    state_next     = ukt_pkg::ST_RESP;
                end
            end
            ukt_pkg::ST_LAST: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = count_dec[IDX_W-1:0];
                state_next  = ukt_pkg::ST_MOVE;
            end
            ukt_pkg::ST_MOVE: begin
                // last entry lands in the hit slot, possibly onto itself
                ram_wr_en   = 1'b1;
                ram_wr_addr = res_slot_reg;
                ram_wr_data = ram_rd_data;
                count_next  = count_dec;
                state_next  = ukt_pkg::ST_RESP;
            end
            ukt_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_success_next = res_ok_reg;
                    m_slot_next    = slot_wide[ukt_pkg::SLOT_W-1:0];
                    m_count_next   = count_wide[ukt_pkg::COUNT_W-1:0];
                    state_next     = ukt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ukt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ukt_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        res_ok_reg    <= res_ok_next;
        res_slot_reg  <= res_slot_next;
        m_success_reg <= m_success_next;
        m_slot_reg    <= m_slot_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_success     = m_success_reg;
    assign m_slot        = m_slot_reg;
    assign m_entry_count = m_count_reg;

`include "unordered_key_table_unit_assert.svh"

    // one word in flight at a time
    `UKT_ASSERT_NEXT(a_one_in_flight, s_accept, !s_ready)
    // the count moves only on a stored insert or a remove writeback
    `UKT_ASSERT_NEXT(a_count_hold,
        !(s_accept && s_operation == ukt_pkg::OP_INSERT) && state_reg != ukt_pkg::ST_MOVE,
        $stable(count_reg))
    // the table never grows past its capacity
    `UKT_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // a ready result leaves the response state with a word on the output
    `UKT_ASSERT_NEXT(a_resp_loads,
        state_reg == ukt_pkg::ST_RESP && (!m_valid_reg || m_ready),
        m_valid_reg && s_ready)

endmodule
